@@ design/sabc_pkg.sv @@
// ============================================================================
// sabc_pkg: shared types and tables for the sector access bits codec
// Holds the transaction structs and the permission decode table.
// ============================================================================
`default_nettype none

package sabc_pkg;

    // Action codes carried in the request.
    localparam logic ACTION_ENCODE = 1'b0;
    localparam logic ACTION_DECODE = 1'b1;

    // Nibble mask and the zero filler byte.
    localparam logic [3:0] NIB_MASK  = 4'h F;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // One input transaction.
    typedef struct packed {
        logic       action;
        logic       key_a_read;
        logic       key_a_write;
        logic       key_b_read;
        logic       key_b_write;
        logic [7:0] in_byte_six;
        logic [7:0] in_byte_seven;
        logic [7:0] in_byte_eight;
    } req_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_byte_six;
        logic [7:0] out_byte_seven;
        logic [7:0] out_byte_eight;
        logic [7:0] out_byte_nine;
        logic       bytes_valid;
        logic       unsupported;
        logic       dec_a_read;
        logic       dec_a_write;
        logic       dec_b_read;
        logic       dec_b_write;
    } rsp_t;

    // Permission table indexed by {C3, C2, C1}; bits are aR, aW, bR, bW.
    function automatic logic [3:0] perm_lookup(input logic [2:0] idx);
        logic [3:0] perm;
        case (idx)
            3'b000:  perm = 4'hF;
            3'b001:  perm = 4'hE;
            3'b010:  perm = 4'hB;
            3'b011:  perm = 4'hA;
            3'b100:  perm = 4'h3;
            3'b101:  perm = 4'h3;
            3'b110:  perm = 4'h1;
            default: perm = 4'h0;
        endcase
        return perm;
    endfunction

endpackage

`default_nettype wire

@@ design/sabc_encoder.sv @@
// ============================================================================
// sabc_encoder: permission bits to access-condition bytes
// Maps the four data-block permissions to a C1/C2/C3 triple and packs the
// three access bytes in the standard inverted-nibble layout.
// ============================================================================
`default_nettype none

module sabc_encoder (
    input  wire sabc_pkg::req_t request,
    output sabc_pkg::rsp_t      response
);

    logic       c1;
    logic       c2;
    logic       c3;
    logic       supported;
    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] n3;
    logic [3:0] perms;

    // Pick the triple for the supported permission combinations.
    always_comb
    begin
        perms     = {request.key_a_read, request.key_a_write,
                     request.key_b_read, request.key_b_write};
        supported = 1'b1;
        c1        = 1'b0;
        c2        = 1'b0;
        c3        = 1'b0;
        case (perms)
            4'b1011: begin c1 = 1'b0; c2 = 1'b1; end
            4'b1111: begin c1 = 1'b0; c2 = 1'b0; end
            4'b1110: begin c1 = 1'b1; c2 = 1'b0; end
            4'b1010: begin c1 = 1'b1; c2 = 1'b1; end
            default: supported = 1'b0;
        endcase
    end

    // Blocks 0 to 2 share the triple; the trailer gets C1=1, C2=1, C3=0.
    assign n1 = {1'b1, {3{c1}}};
    assign n2 = {1'b1, {3{c2}}};
    assign n3 = {1'b0, {3{c3}}};

    // Pack the bytes, or zeros when the combination has no mapping.
    always_comb
    begin
        response                = '0;
        response.bytes_valid    = 1'b1;
        response.unsupported    = ~supported;
        response.out_byte_nine  = sabc_pkg::ZERO_BYTE;
        if (supported)
        begin
            response.out_byte_six   = {~n2 & sabc_pkg::NIB_MASK, ~n1 & sabc_pkg::NIB_MASK};
            response.out_byte_seven = {n1, ~n3 & sabc_pkg::NIB_MASK};
            response.out_byte_eight = {n3, n2};
        end
    end

endmodule

`default_nettype wire

@@ design/sabc_decoder.sv @@
// ============================================================================
// sabc_decoder: access-condition bytes to permission bits
// Checks the inverted nibble copies and decodes block 0's triple.
// ============================================================================
`default_nettype none

module sabc_decoder (
    input  wire sabc_pkg::req_t request,
    output sabc_pkg::rsp_t      response
);

    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] n3;
    logic       ok;
    logic [3:0] perm;

    // Plain nibbles from the standard layout.
    assign n1 = request.in_byte_seven[7:4];
    assign n2 = request.in_byte_eight[3:0];
    assign n3 = request.in_byte_eight[7:4];

    // Each inverted nibble must be the complement of its plain copy.
    assign ok = ((~request.in_byte_six[3:0]   & sabc_pkg::NIB_MASK) == n1) &&
                ((~request.in_byte_six[7:4]   & sabc_pkg::NIB_MASK) == n2) &&
                ((~request.in_byte_seven[3:0] & sabc_pkg::NIB_MASK) == n3);

    // Block 0's triple selects the permission set.
    assign perm = sabc_pkg::perm_lookup({n3[0], n2[0], n1[0]});

    always_comb
    begin
        response             = '0;
        response.bytes_valid = ok;
        response.dec_a_read  = perm[3];
        response.dec_a_write = perm[2];
        response.dec_b_read  = perm[1];
        response.dec_b_write = perm[0];
    end

endmodule

`default_nettype wire

@@ design/sector_access_bits_codec_unit.sv @@
// ============================================================================
// sector_access_bits_codec_unit: sector trailer access bits codec
// A result appears with done once the request has passed the input register and then the result register.
// Throughput: one transaction per cycle; busy stays low, the datapath is an
// input register, one level of codec logic and a result register.
// Reset clears the valid flags, so no done strobe follows reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ============================================================================
`default_nettype none

module sector_access_bits_codec_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire sabc_pkg::req_t request,
    output logic                done,
    output sabc_pkg::rsp_t      response
);

    logic           req_valid_reg;
    sabc_pkg::req_t req_reg;
    logic           rsp_valid_reg;
    sabc_pkg::rsp_t rsp_reg;
    sabc_pkg::rsp_t enc_rsp;
    sabc_pkg::rsp_t dec_rsp;
    sabc_pkg::rsp_t rsp_next;

    // The pipeline never holds off a new transaction.
    assign busy = 1'b0;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    // Both codec directions work on the registered request.
    sabc_encoder u_encoder (
        .request  (req_reg),
        .response (enc_rsp)
    );

    sabc_decoder u_decoder (
        .request  (req_reg),
        .response (dec_rsp)
    );

    // Select the direction named by the action code.
    assign rsp_next = (req_reg.action == sabc_pkg::ACTION_DECODE) ? dec_rsp : enc_rsp;

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done     = rsp_valid_reg;
    assign response = rsp_reg;

    // A result strobe always follows an accepted transaction through the input and result registers.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("done without a matching accepted transaction");

    // An unmapped permission set gives zero bytes and still reports valid.
    a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.unsupported) |->
            (response.bytes_valid && response.out_byte_six == sabc_pkg::ZERO_BYTE &&
             response.out_byte_seven == sabc_pkg::ZERO_BYTE &&
             response.out_byte_eight == sabc_pkg::ZERO_BYTE))
        else $error("unsupported result carries nonzero bytes or invalid flag");

    // The general purpose byte is always zero on a delivered result.
    a_byte_nine_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (response.out_byte_nine == sabc_pkg::ZERO_BYTE))
        else $error("general purpose byte is not zero");

endmodule

`default_nettype wire

@@ tb/sv/sector_access_bits_codec_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sector_access_bits_codec_unit_tb: self-checking testbench for the codec
// Sends encode and decode transactions through the start/busy handshake,
// predicts every result from the access-bit rules and compares each done
// strobe against the oldest prediction. Sender idling varies by phase.
// ============================================================================

module sector_access_bits_codec_unit_tb;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_ITEMS  = 345;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    sabc_pkg::req_t request = '0;
    logic busy;
    logic done;
    sabc_pkg::rsp_t response;

    sabc_pkg::req_t pending_reqs[$];
    sabc_pkg::rsp_t expected_rsps[$];
    sabc_pkg::rsp_t oldest_rsp;
    sabc_pkg::rsp_t accepted_rsp;

    int unsigned sender_idle_pct = 0;
    int unsigned stall_cycles    = 0;
    int          error_count     = 0;
    int          encode_count    = 0;
    int          unsupported_count = 0;
    int          decode_count    = 0;
    int          broken_count    = 0;
    int          result_count    = 0;

    sector_access_bits_codec_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    // Free-running clock.
    initial
    begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Expected result of one transaction, following the trailer bit layout.
    function automatic sabc_pkg::rsp_t predict_trailer_access(input sabc_pkg::req_t r);
        sabc_pkg::rsp_t rsp;
        logic [2:0]     triple;
        logic [3:0]     n1;
        logic [3:0]     n2;
        logic [3:0]     n3;
        logic [3:0]     perm;
        logic           mapped;
        rsp    = '0;
        triple = '0;
        mapped = 1'b1;
        if (r.action == sabc_pkg::ACTION_ENCODE)
        begin
            rsp.bytes_valid = 1'b1;
            // Permission bits aR, aW, bR, bW select the C1, C2, C3 triple.
            case ({r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write})
                4'b1011: triple = 3'b010;
                4'b1111: triple = 3'b000;
                4'b1110: triple = 3'b100;
                4'b1010: triple = 3'b110;
                default: mapped = 1'b0;
            endcase
            if (!mapped)
            begin
                rsp.unsupported = 1'b1;
            end
            else
            begin
                // Data blocks share the triple; the trailer is always C1=1, C2=1, C3=0.
                n1 = {1'b1, {3{triple[2]}}};
                n2 = {1'b1, {3{triple[1]}}};
                n3 = {1'b0, {3{triple[0]}}};
                rsp.out_byte_six   = {~n2, ~n1};
                rsp.out_byte_seven = {n1, ~n3};
                rsp.out_byte_eight = {n3, n2};
            end
        end
        else
        begin
            n1 = r.in_byte_seven[7:4];
            n2 = r.in_byte_eight[3:0];
            n3 = r.in_byte_eight[7:4];
            rsp.bytes_valid = (r.in_byte_six[3:0] == ~n1) &&
                              (r.in_byte_six[7:4] == ~n2) &&
                              (r.in_byte_seven[3:0] == ~n3);
            // Block 0's triple picks the permissions, whether or not the bytes agree.
            case ({n3[0], n2[0], n1[0]})
                3'b000:  perm = 4'hF;
                3'b001:  perm = 4'hE;
                3'b010:  perm = 4'hB;
                3'b011:  perm = 4'hA;
                3'b100:  perm = 4'h3;
                3'b101:  perm = 4'h3;
                3'b110:  perm = 4'h1;
                default: perm = 4'h0;
            endcase
            {rsp.dec_a_read, rsp.dec_a_write, rsp.dec_b_read, rsp.dec_b_write} = perm;
        end
        return rsp;
    endfunction

    // Turns a request into a decode of consistent bytes built from the plain nibbles.
    function automatic sabc_pkg::req_t with_trailer_nibbles(input sabc_pkg::req_t base,
                                                            input logic [3:0] n1,
                                                            input logic [3:0] n2,
                                                            input logic [3:0] n3);
        sabc_pkg::req_t r;
        r               = base;
        r.action        = sabc_pkg::ACTION_DECODE;
        r.in_byte_six   = {~n2, ~n1};
        r.in_byte_seven = {n1, ~n3};
        r.in_byte_eight = {n3, n2};
        return r;
    endfunction

    // Appends one transaction to the tail of the send queue.
    task automatic add_request(input sabc_pkg::req_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic check_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", field, exp_val, act_val);
            error_count++;
        end
    endtask

    // Waits until every queued transaction is taken and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
    endtask

    // One random phase: mostly consistent decodes and encodes, some broken bytes.
    task automatic run_phase(input int unsigned idle_pct);
        sabc_pkg::req_t r;
        int unsigned    kind;
        logic [23:0]    flip;
        @(negedge clk);
        sender_idle_pct = idle_pct;
        repeat (PHASE_ITEMS)
        begin
            r    = sabc_pkg::req_t'($urandom);
            kind = $urandom_range(99, 0);
            if (kind < 35)
            begin
                r.action = sabc_pkg::ACTION_ENCODE;
                if ($urandom_range(1, 0) == 1)
                begin
                    case ($urandom_range(3, 0))
                        0:       {r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write} = 4'b1011;
                        1:       {r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write} = 4'b1111;
                        2:       {r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write} = 4'b1110;
                        default: {r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write} = 4'b1010;
                    endcase
                end
            end
            else if (kind < 90)
            begin
                r = with_trailer_nibbles(r, 4'($urandom), 4'($urandom), 4'($urandom));
                // A single flipped bit always breaks exactly one inverted-nibble check.
                if (kind >= 75)
                begin
                    flip = 24'd1 << $urandom_range(23, 0);
                    {r.in_byte_six, r.in_byte_seven, r.in_byte_eight} =
                        {r.in_byte_six, r.in_byte_seven, r.in_byte_eight} ^ flip;
                end
            end
            else
            begin
                r.action = sabc_pkg::ACTION_DECODE;
            end
            add_request(r);
        end
        wait_drained();
    endtask

    // Driver: records each accepted transaction and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                accepted_rsp  = predict_trailer_access(request);
                expected_rsps = {expected_rsps, accepted_rsp};
                if (request.action == sabc_pkg::ACTION_DECODE)
                begin
                    decode_count++;
                    if (!accepted_rsp.bytes_valid)
                        broken_count++;
                end
                else
                begin
                    encode_count++;
                    if (accepted_rsp.unsupported)
                        unsupported_count++;
                end
            end
            if (!start || !busy)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    start   <= 1'b1;
                    request <= pending_reqs.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each done strobe is compared with the oldest expected result.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("result arrived with no transaction outstanding");
                error_count++;
            end
            else
            begin
                oldest_rsp = expected_rsps.pop_front();
                result_count++;
                check_field("out_byte_six", oldest_rsp.out_byte_six, response.out_byte_six);
                check_field("out_byte_seven", oldest_rsp.out_byte_seven,
                            response.out_byte_seven);
                check_field("out_byte_eight", oldest_rsp.out_byte_eight,
                            response.out_byte_eight);
                check_field("out_byte_nine", oldest_rsp.out_byte_nine, response.out_byte_nine);
                check_field("bytes_valid", 8'(oldest_rsp.bytes_valid), 8'(response.bytes_valid));
                check_field("unsupported", 8'(oldest_rsp.unsupported), 8'(response.unsupported));
                check_field("dec_a_read", 8'(oldest_rsp.dec_a_read), 8'(response.dec_a_read));
                check_field("dec_a_write", 8'(oldest_rsp.dec_a_write), 8'(response.dec_a_write));
                check_field("dec_b_read", 8'(oldest_rsp.dec_b_read), 8'(response.dec_b_read));
                check_field("dec_b_write", 8'(oldest_rsp.dec_b_write), 8'(response.dec_b_write));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sector_access_bits_codec_unit verification failed");
                $finish;
            end
        end
    end

    // Reset, directed transactions, random phases and the final verdict.
    initial
    begin
        sabc_pkg::req_t r;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every encode permission combination, supported and unsupported.
        for (int p = 0; p < 16; p++)
        begin
            r        = '0;
            r.action = sabc_pkg::ACTION_ENCODE;
            {r.key_a_read, r.key_a_write, r.key_b_read, r.key_b_write} = 4'(p);
            add_request(r);
        end
        // Every block 0 triple with consistent bytes, then all-zero and all-one bytes.
        for (int t = 0; t < 8; t++)
        begin
            add_request(with_trailer_nibbles('0, {4{t[0]}}, {4{t[1]}}, {4{t[2]}}));
        end
        r        = '0;
        r.action = sabc_pkg::ACTION_DECODE;
        add_request(r);
        r.in_byte_six   = 8'hFF;
        r.in_byte_seven = 8'hFF;
        r.in_byte_eight = 8'hFF;
        add_request(r);
        // Hold off the sender until the directed results are all back.
        wait_drained();

        run_phase(0);
        run_phase(88);
        run_phase(0);
        run_phase(36);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_rsps.size());
            error_count++;
        end

        $display("Covered %0d encodes (%0d unsupported) and %0d decodes (%0d inconsistent),",
                 encode_count, unsupported_count, decode_count, broken_count);
        $display("with %0d results checked over phases of 0, 88 and 36 percent sender idling.",
                 result_count);
        if (error_count == 0)
        begin
            $display("sector_access_bits_codec_unit verification clean");
        end
        else
        begin
            $display("sector_access_bits_codec_unit verification failed");
        end
        $finish;
    end

endmodule
